@@ hw/rtl/ccr_pkg.sv @@
// Shared types and constants of the closed Catmull-Rom path follower.
// No dependencies; every other file of the block uses this package.
package ccr_pkg;

   localparam int COORD_W = 32;
   localparam int POINT_W = 3 * COORD_W;
   localparam int DT_W    = 16;
   localparam int SPEED_W = 24;
   localparam int FRAC_W  = 16;
   localparam int RW      = 40;
   localparam int PRW     = RW + DT_W + 1;
   localparam int MIN_POINTS = 4;

   localparam logic [SPEED_W-1:0] SPEED_RESET = 24'd65536;
   localparam logic ACTION_ADD  = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   typedef enum logic {
      OP_ADD,
      OP_TICK
   } ccr_op_type;

   typedef struct packed {
      ccr_op_type          op;
      logic [POINT_W-1:0]  point;
      logic [DT_W-1:0]     dt;
   } ccr_cmd_type;

endpackage

@@ hw/rtl/ccr_if.sv @@
// Channel interfaces of the closed Catmull-Rom path follower.
// Depends on ccr_pkg for field widths.
interface ccr_req_if;
   logic                                valid;
   logic                                ready;
   logic                                action;
   logic signed [ccr_pkg::COORD_W-1:0]  point_x;
   logic signed [ccr_pkg::COORD_W-1:0]  point_y;
   logic signed [ccr_pkg::COORD_W-1:0]  point_z;
   logic [ccr_pkg::DT_W-1:0]            delta_time;
   modport source (output valid, action, point_x, point_y, point_z, delta_time,
                   input ready);
   modport sink   (input valid, action, point_x, point_y, point_z, delta_time,
                   output ready);
endinterface

interface ccr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [ccr_pkg::COORD_W-1:0]  pos_x;
   logic signed [ccr_pkg::COORD_W-1:0]  pos_y;
   logic signed [ccr_pkg::COORD_W-1:0]  pos_z;
   modport source (output valid, pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface ccr_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ccr_pkg::SPEED_W-1:0]         data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ hw/rtl/ccr_queue.sv @@
// Two-entry command queue between the front and back parts.
// Depends on ccr_pkg for the command type.
module ccr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  ccr_pkg::ccr_cmd_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output ccr_pkg::ccr_cmd_type pop_data
);
   import ccr_pkg::*;

   ccr_cmd_type slot_ff [2];
   logic        wr_ff;
   logic        rd_ff;
   logic [1:0]  cnt_ff;
   logic        push;
   logic        pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end
endmodule

@@ hw/rtl/ccr_front.sv @@
// Front part: accepts request beats, drops those that change nothing and
// queues add and tick commands. Depends on ccr_pkg and ccr_if.
module ccr_front #(
   parameter int MAX_POINTS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   ccr_req_if.sink              req,
   output logic                 push_valid,
   input  logic                 push_ready,
   output ccr_pkg::ccr_cmd_type push_data
);
   import ccr_pkg::*;

   localparam int CW = $clog2(MAX_POINTS + 1);

   logic [CW-1:0] count_ff;
   logic          accept;
   logic          is_add;
   logic          keep;

   assign req.ready = push_ready;
   assign accept    = req.valid && push_ready;
   assign is_add    = (req.action == ACTION_ADD);
   assign keep      = is_add ? (count_ff != CW'(MAX_POINTS)) : (count_ff >= CW'(MIN_POINTS));
   assign push_valid = accept && keep;

   assign push_data.op    = is_add ? OP_ADD : OP_TICK;
   assign push_data.point = {req.point_x, req.point_y, req.point_z};
   assign push_data.dt    = req.delta_time;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (push_valid && is_add) begin
         count_ff <= count_ff + 1'b1;
      end
   end
endmodule

@@ hw/rtl/ccr_back.sv @@
// Back part: point memory, progress update with iterative wrap, and the
// three-lane cubic evaluation. Depends on ccr_pkg and ccr_if.
module ccr_back #(
   parameter int MAX_POINTS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   output logic                      pop_ready,
   input  ccr_pkg::ccr_cmd_type      pop_data,
   input  logic [ccr_pkg::SPEED_W-1:0] speed,
   ccr_rsp_if.source                 rsp
);
   import ccr_pkg::*;

   localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW   = $clog2(MAX_POINTS + 1);
   localparam int PW   = AW + FRAC_W;
   localparam int SW   = ((PW > SPEED_W) ? PW : SPEED_W) + 1;
   localparam int KMAX = 6;
   localparam int XW   = (SW > CW + FRAC_W + KMAX) ? SW : CW + FRAC_W + KMAX;
   localparam int STW  = SPEED_W + DT_W;

   typedef enum logic [3:0] {
      S_IDLE, S_SUM, S_MOD, S_IDX, S_RD, S_COEF, S_MUL, S_ADD, S_OUT
   } state_type;

   state_type            state_ff;
   logic [CW-1:0]        n_ff;
   logic [PW-1:0]        prog_ff;
   logic [STW-1:0]       step_ff;
   logic [SW-1:0]        sum_ff;
   logic [2:0]           k_ff;
   logic [2:0]           rd_cnt_ff;
   logic [1:0]           h_ff;
   logic [AW-1:0]        addr_ff [4];
   logic [FRAC_W-1:0]    t_ff;
   logic [POINT_W-1:0]   mem [MAX_POINTS];
   logic [POINT_W-1:0]   mem_q_ff;
   logic [POINT_W-1:0]   p_ff [4];
   logic signed [RW-1:0] r_ff [3];
   logic signed [PRW-1:0] prod_ff [3];
   logic signed [RW-1:0] c2_ff [3];
   logic signed [RW-1:0] c1_ff [3];
   logic signed [RW-1:0] c0_ff [3];
   logic signed [COORD_W-1:0] out_ff [3];
   logic                 out_valid_ff;

   logic                 take;
   logic                 load_out;
   logic [XW-1:0]        shifted;
   logic [XW-1:0]        sum_x;
   logic [AW-1:0]        idx;
   logic [AW-1:0]        i_prev;
   logic [AW-1:0]        i_next;
   logic [AW-1:0]        i_next2;
   logic signed [RW-1:0] pe [4][3];
   logic signed [RW-1:0] a3 [3];
   logic signed [RW-1:0] a2 [3];
   logic signed [RW-1:0] a1 [3];
   logic signed [RW-1:0] a0 [3];
   logic signed [RW-1:0] half [3];
   logic signed [COORD_W-1:0] sat [3];

   assign pop_ready = (state_ff == S_IDLE);
   assign take      = pop_valid && pop_ready;
   assign load_out  = (state_ff == S_OUT) && (!out_valid_ff || rsp.ready);

   assign sum_x   = XW'(sum_ff);
   assign shifted = XW'(n_ff) << (FRAC_W + int'(k_ff));

   assign idx     = sum_ff[PW-1:FRAC_W];
   assign i_prev  = (idx == '0) ? AW'(n_ff - 1'b1) : AW'(idx - 1'b1);
   assign i_next  = ((CW'(idx) + 1'b1) == n_ff) ? '0 : AW'(idx + 1'b1);
   assign i_next2 = ((CW'(i_next) + 1'b1) == n_ff) ? '0 : AW'(i_next + 1'b1);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int j = 0; j < 4; j++) begin
            pe[j][c] = RW'($signed(p_ff[j][POINT_W-1-COORD_W*c -: COORD_W]));
         end
         a3[c] = -pe[0][c] + (pe[1][c] <<< 1) + pe[1][c]
                 - (pe[2][c] <<< 1) - pe[2][c] + pe[3][c];
         a2[c] = (pe[0][c] <<< 1) - (pe[1][c] <<< 2) - pe[1][c]
                 + (pe[2][c] <<< 2) - pe[3][c];
         a1[c] = pe[2][c] - pe[0][c];
         a0[c] = pe[1][c] <<< 1;
         half[c] = r_ff[c] >>> 1;
         if (half[c] > RW'(64'sd2147483647)) begin
            sat[c] = 32'sh7FFF_FFFF;
         end else if (half[c] < -RW'(64'sd2147483648)) begin
            sat[c] = 32'sh8000_0000;
         end else begin
            sat[c] = half[c][COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         n_ff         <= '0;
         prog_ff      <= '0;
         k_ff         <= '0;
         rd_cnt_ff    <= '0;
         h_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (take) begin
                  if (pop_data.op == OP_ADD) begin
                     n_ff    <= n_ff + 1'b1;
                     prog_ff <= '0;
                  end else begin
                     state_ff <= S_SUM;
                  end
               end
            end
            S_SUM: begin
               k_ff     <= 3'(KMAX);
               state_ff <= S_MOD;
            end
            S_MOD: begin
               if (k_ff == '0) begin
                  state_ff <= S_IDX;
               end else begin
                  k_ff <= k_ff - 1'b1;
               end
            end
            S_IDX: begin
               prog_ff   <= sum_ff[PW-1:0];
               rd_cnt_ff <= '0;
               state_ff  <= S_RD;
            end
            S_RD: begin
               if (rd_cnt_ff == 3'd4) begin
                  state_ff <= S_COEF;
               end else begin
                  rd_cnt_ff <= rd_cnt_ff + 1'b1;
               end
            end
            S_COEF: begin
               h_ff     <= '0;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               state_ff <= S_ADD;
            end
            S_ADD: begin
               if (h_ff == 2'd2) begin
                  state_ff <= S_OUT;
               end else begin
                  h_ff     <= h_ff + 1'b1;
                  state_ff <= S_MUL;
               end
            end
            S_OUT: begin
               if (load_out) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (take && pop_data.op == OP_ADD) begin
         mem[n_ff[AW-1:0]] <= pop_data.point;
      end
      mem_q_ff <= mem[addr_ff[rd_cnt_ff[1:0]]];
   end

   always_ff @(posedge clock) begin
      if (take) begin
         step_ff <= STW'(speed * pop_data.dt);
      end
      if (state_ff == S_SUM) begin
         sum_ff <= SW'(prog_ff) + SW'(step_ff[STW-1:FRAC_W]);
      end
      if (state_ff == S_MOD && sum_x >= shifted) begin
         sum_ff <= SW'(sum_x - shifted);
      end
      if (state_ff == S_IDX) begin
         addr_ff[0] <= i_prev;
         addr_ff[1] <= idx;
         addr_ff[2] <= i_next;
         addr_ff[3] <= i_next2;
         t_ff       <= sum_ff[FRAC_W-1:0];
      end
      if (state_ff == S_RD && rd_cnt_ff != 3'd0) begin
         p_ff[rd_cnt_ff[1:0] - 2'd1] <= mem_q_ff;
      end
      for (int c = 0; c < 3; c++) begin
         if (state_ff == S_COEF) begin
            r_ff[c]  <= a3[c];
            c2_ff[c] <= a2[c];
            c1_ff[c] <= a1[c];
            c0_ff[c] <= a0[c];
         end
         if (state_ff == S_MUL) begin
            prod_ff[c] <= r_ff[c] * $signed({1'b0, t_ff});
         end
         if (state_ff == S_ADD) begin
            case (h_ff)
               2'd0:    r_ff[c] <= $signed(prod_ff[c][FRAC_W +: RW]) + c2_ff[c];
               2'd1:    r_ff[c] <= $signed(prod_ff[c][FRAC_W +: RW]) + c1_ff[c];
               default: r_ff[c] <= $signed(prod_ff[c][FRAC_W +: RW]) + c0_ff[c];
            endcase
         end
         if (load_out) begin
            out_ff[c] <= sat[c];
         end
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.pos_x = out_ff[0];
   assign rsp.pos_y = out_ff[1];
   assign rsp.pos_z = out_ff[2];

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      n_ff <= CW'(MAX_POINTS))
      else $error("Point count exceeds the store depth.");

   a_wrapped : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDX |-> sum_x < (XW'(n_ff) << FRAC_W))
      else $error("Progress not reduced below the loop length.");

   a_out_load : assert property (@(posedge clock) disable iff (reset)
      load_out |=> out_valid_ff)
      else $error("Loaded result is not presented.");
endmodule

@@ hw/rtl/closed_catmull_rom_path_follower.sv @@
// Top level of the closed Catmull-Rom path follower: speed register, front
// part, command queue and back part. Depends on ccr_pkg, ccr_if and submodules.
//
//   Channel  Dir  Beat carries
//   req      in   action, point_x, point_y, point_z, delta_time
//   rsp      out  pos_x, pos_y, pos_z (one per tick with four or more points)
//   csr      in   path_speed, unsigned Q8.16
//
// The back part stores an add beat without leaving idle; a tick runs the
// seven-step progress wrap, four point memory reads and three multiply-add
// rounds before a new command is taken. The front keeps accepting while the
// queue has room. Reset is synchronous and leaves the point memory unwritten.
module closed_catmull_rom_path_follower #(
   parameter int MAX_POINTS = 64
) (
   input  logic      clock,
   input  logic      reset,
   ccr_req_if.sink   req,
   ccr_rsp_if.source rsp,
   ccr_csr_if.sink   csr
);
   import ccr_pkg::*;

   logic [SPEED_W-1:0] speed_ff;
   logic               push_valid;
   logic               push_ready;
   ccr_cmd_type        push_data;
   logic               pop_valid;
   logic               pop_ready;
   ccr_cmd_type        pop_data;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= SPEED_RESET;
      end else if (csr.valid) begin
         speed_ff <= csr.data;
      end
   end

   ccr_front #(.MAX_POINTS(MAX_POINTS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ccr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ccr_back #(.MAX_POINTS(MAX_POINTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .speed     (speed_ff),
      .rsp       (rsp)
   );
endmodule
